// ===== sv/dgpid_pkg.sv =====
// dgpid_pkg: shared widths, register indexes, multiplier operand codes and
// the controller-to-datapath command type for the dual-gain PID core.
// No dependencies.
package dgpid_pkg;

  localparam int GAIN_W     = 32;   // gain register width, signed
  localparam int INTEG_W    = 48;   // error integral width, signed
  localparam int NUM_REGS   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_RECIP = 100;  // 1 / dt for dt = 0.01

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_KD = 3'd5;

  // shared multiplier operand pairs
  localparam logic [1:0] OP_STEP  = 2'd0;  // dt * e
  localparam logic [1:0] OP_PROP  = 2'd1;  // kp * e
  localparam logic [1:0] OP_INTEG = 2'd2;  // ki * integral
  localparam logic [1:0] OP_DERIV = 2'd3;  // kd * derivative

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gain_set_t;

  typedef struct packed {
    logic       load;       // capture input transaction
    logic       calc_err;   // register clamped error
    logic [1:0] mul_op;     // operand pair for the multiplier
    logic       mul_hi;     // high chunk of operand B
    logic       acc_clr;    // start a new sum
    logic       acc_add;    // add last product
    logic       acc_hi;     // last product was a high chunk
    logic       upd_integ;  // commit integral, derivative, last error
    logic       out_load;   // load result register
  } dp_cmd_t;

endpackage

// ===== sv/dual_gain_pid_controller_core.sv =====
// Dual-gain PID controller core: top level.
// Depends on dgpid_pkg, dgpid_regs, dgpid_ctrl and dgpid_dp.
//
// Usage
//   Input channel (in_valid / in_stall): one control sample per transaction:
//   velocity, acceleration, setpoint and loop select (1 = velocity loop with
//   the velocity gains, 0 = acceleration loop with the acceleration gains).
//   Output channel (out_valid / out_stall): one transaction per sample, the
//   saturated drive value and a flag set when integral or output clipped.
//   Config channel (cfg_valid / cfg_ready): gain index 0..5 and Q-format data;
//   cfg_ready is always high, writes to indexes 6 and 7 are dropped. Write
//   gains only while no sample is in flight.
// Sequence
//   A sample runs through capture, error clamp, then nine steps through
//   the one shared 32 x 25 bit multiplier (two chunks for each of dt*e, kp*e,
//   ki*I and kd*D, plus one drain step into the accumulator), then the hand-off
//   into the result register. in_stall stays high until that hand-off, so the
//   next sample is not taken before the last one is handed off.
// Reset (rst_n, synchronous): gains return to their defaults, integral and
//   last error are cleared, no result is pending.
// Stall: a stalled result holds in the output register; the next sample is
//   still taken and computed, and waits at the hand-off until it is free.
module dual_gain_pid_controller_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // control sample in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DATA_WIDTH-1:0]        in_velocity,
  input  logic signed [DATA_WIDTH-1:0]        in_acceleration,
  input  logic signed [DATA_WIDTH-1:0]        in_target,
  input  logic                                in_loop_select,
  // drive value out
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DATA_WIDTH-1:0]        out_drive_output,
  output logic                                out_saturated,
  // gain writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dgpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dgpid_pkg::GAIN_W-1:0]        cfg_data
);

  dgpid_pkg::gain_set_t vel_gains;
  dgpid_pkg::gain_set_t acc_gains;
  dgpid_pkg::dp_cmd_t   cmd;

  // gain register file
  dgpid_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vel_gains (vel_gains),
    .acc_gains (acc_gains)
  );

  // sequencer: owns the handshakes, issues one command word a cycle
  dgpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: arithmetic, loop state, result register
  dgpid_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .vel_gains        (vel_gains),
    .acc_gains        (acc_gains),
    .in_velocity      (in_velocity),
    .in_acceleration  (in_acceleration),
    .in_target        (in_target),
    .in_loop_select   (in_loop_select),
    .out_drive_output (out_drive_output),
    .out_saturated    (out_saturated)
  );

endmodule

// ===== sv/dgpid_regs.sv =====
// dgpid_regs: the six gain registers and their write port.
// Depends on dgpid_pkg.
module dgpid_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [dgpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dgpid_pkg::GAIN_W-1:0]            cfg_data,
  output dgpid_pkg::gain_set_t                    vel_gains,
  output dgpid_pkg::gain_set_t                    acc_gains
);

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_VEL_KP = dgpid_pkg::GAIN_W'(50 * ONE_Q);
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_VEL_KI = dgpid_pkg::GAIN_W'(15 * ONE_Q);
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_VEL_KD = dgpid_pkg::GAIN_W'((ONE_Q + 5) / 10);
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_ACC_KP =
    dgpid_pkg::GAIN_W'((8 * ONE_Q + 5) / 10);
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_ACC_KI = dgpid_pkg::GAIN_W'((ONE_Q + 5) / 10);
  localparam logic [dgpid_pkg::GAIN_W-1:0] RST_ACC_KD = '0;

  logic [dgpid_pkg::GAIN_W-1:0] gain_r [dgpid_pkg::NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[dgpid_pkg::REG_VEL_KP] <= RST_VEL_KP;
      gain_r[dgpid_pkg::REG_VEL_KI] <= RST_VEL_KI;
      gain_r[dgpid_pkg::REG_VEL_KD] <= RST_VEL_KD;
      gain_r[dgpid_pkg::REG_ACC_KP] <= RST_ACC_KP;
      gain_r[dgpid_pkg::REG_ACC_KI] <= RST_ACC_KI;
      gain_r[dgpid_pkg::REG_ACC_KD] <= RST_ACC_KD;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < dgpid_pkg::CFG_IDX_W'(dgpid_pkg::NUM_REGS))) begin
      gain_r[cfg_index] <= cfg_data;  // unused indexes are dropped
    end
  end

  assign vel_gains.kp = gain_r[dgpid_pkg::REG_VEL_KP];
  assign vel_gains.ki = gain_r[dgpid_pkg::REG_VEL_KI];
  assign vel_gains.kd = gain_r[dgpid_pkg::REG_VEL_KD];
  assign acc_gains.kp = gain_r[dgpid_pkg::REG_ACC_KP];
  assign acc_gains.ki = gain_r[dgpid_pkg::REG_ACC_KI];
  assign acc_gains.kd = gain_r[dgpid_pkg::REG_ACC_KD];

endmodule

// ===== sv/dgpid_ctrl.sv =====
// dgpid_ctrl: sequencer for one control sample and the result valid flag.
// Drives dgpid_dp through dp_cmd_t. Depends on dgpid_pkg.
module dgpid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output dgpid_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ERR  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // step 3 also commits the integral; step 8 only drains the last product
  localparam logic [3:0] INT_STEP  = 4'd3;
  localparam logic [3:0] LAST_STEP = 4'd8;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.calc_err = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_op    = step_r[2:1];
        cmd.mul_hi    = step_r[0];
        cmd.acc_add   = (step_r != 4'd0);
        cmd.acc_hi    = ~step_r[0];
        cmd.acc_clr   = (step_r == 4'd1) || (step_r == INT_STEP);
        cmd.upd_integ = (step_r == INT_STEP);
        if (step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/dgpid_dp.sv =====
// dgpid_dp: error, integral and derivative registers, shared chunked
// multiplier, wide accumulator and result register. Depends on dgpid_pkg.
module dgpid_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dgpid_pkg::dp_cmd_t            cmd,
  input  dgpid_pkg::gain_set_t          vel_gains,
  input  dgpid_pkg::gain_set_t          acc_gains,
  input  logic signed [DATA_WIDTH-1:0]  in_velocity,
  input  logic signed [DATA_WIDTH-1:0]  in_acceleration,
  input  logic signed [DATA_WIDTH-1:0]  in_target,
  input  logic                          in_loop_select,
  output logic signed [DATA_WIDTH-1:0]  out_drive_output,
  output logic                          out_saturated
);

  localparam int DW      = DATA_WIDTH;
  localparam int GW      = dgpid_pkg::GAIN_W;
  localparam int IW      = dgpid_pkg::INTEG_W;
  localparam int DRV_W   = DW + 8;                        // (e - e_prev) * 100
  localparam int OPB_W   = (DRV_W > IW) ? DRV_W : IW;
  localparam int CHK_W   = (OPB_W + 1) / 2;               // unsigned low chunk
  localparam int MUL_B_W = CHK_W + 1;
  localparam int PROD_W  = GW + MUL_B_W;
  localparam int ACC_W   = GW + OPB_W + 2;
  localparam longint STEP_Q =
    ((longint'(1) << FRAC_BITS) + dgpid_pkg::STEP_RECIP / 2) / dgpid_pkg::STEP_RECIP;

  localparam logic signed [ACC_W-1:0] INT_MAX = {{(ACC_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] INT_MIN = ~INT_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  logic signed [DW-1:0]      meas_r, tgt_r;
  logic                      sel_r;
  logic signed [DW-1:0]      e_r, e_nxt, prev_r;
  logic signed [DW:0]        err_diff, d_diff;
  logic signed [IW-1:0]      integ_r, integ_nxt;
  logic signed [DRV_W-1:0]   deriv_r, deriv_nxt, dx;
  logic                      int_hit, sat_int_r, out_hit;
  dgpid_pkg::gain_set_t      gs;
  logic signed [GW-1:0]      opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [MUL_B_W-1:0] b_chunk;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_term, acc_sh, isum;
  logic signed [DW-1:0]      drive_r, drive_nxt;
  logic                      sat_r;

  // error, clamped to the data range (no flag)
  assign err_diff = (DW+1)'(tgt_r) - (DW+1)'(meas_r);
  always_comb begin
    if (err_diff[DW] != err_diff[DW-1]) begin
      e_nxt = err_diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      e_nxt = err_diff[DW-1:0];
    end
  end

  // derivative: difference times 100 as shift-adds
  assign d_diff    = (DW+1)'(e_r) - (DW+1)'(prev_r);
  assign dx        = DRV_W'(d_diff);
  assign deriv_nxt = (dx <<< 6) + (dx <<< 5) + (dx <<< 2);

  // operand selection, operand B split into two chunks
  assign gs = sel_r ? vel_gains : acc_gains;

  always_comb begin
    unique case (cmd.mul_op)
      dgpid_pkg::OP_STEP: begin
        opa = GW'(STEP_Q);
        opb = OPB_W'(e_r);
      end
      dgpid_pkg::OP_PROP: begin
        opa = gs.kp;
        opb = OPB_W'(e_r);
      end
      dgpid_pkg::OP_INTEG: begin
        opa = gs.ki;
        opb = OPB_W'(integ_r);
      end
      dgpid_pkg::OP_DERIV: begin
        opa = gs.kd;
        opb = OPB_W'(deriv_r);
      end
    endcase
  end

  assign b_chunk  = cmd.mul_hi ? MUL_B_W'($signed(opb[OPB_W-1:CHK_W]))
                               : $signed({1'b0, opb[CHK_W-1:0]});
  assign prod_nxt = opa * b_chunk;

  // accumulate the registered product
  assign acc_term = cmd.acc_hi ? (ACC_W'(prod_r) <<< CHK_W) : ACC_W'(prod_r);
  assign acc_nxt  = (cmd.acc_clr ? '0 : acc_r) + (cmd.acc_add ? acc_term : '0);
  assign acc_sh   = acc_r >>> FRAC_BITS;

  // integral update, clamped to 48 bits
  assign isum = ACC_W'(integ_r) + acc_sh;
  always_comb begin
    int_hit = 1'b0;
    if (isum > INT_MAX) begin
      integ_nxt = INT_MAX[IW-1:0];
      int_hit   = 1'b1;
    end else if (isum < INT_MIN) begin
      integ_nxt = INT_MIN[IW-1:0];
      int_hit   = 1'b1;
    end else begin
      integ_nxt = isum[IW-1:0];
    end
  end

  // output clamp
  always_comb begin
    out_hit = 1'b0;
    if (acc_sh > OUT_MAX) begin
      drive_nxt = OUT_MAX[DW-1:0];
      out_hit   = 1'b1;
    end else if (acc_sh < OUT_MIN) begin
      drive_nxt = OUT_MIN[DW-1:0];
      out_hit   = 1'b1;
    end else begin
      drive_nxt = acc_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r <= in_loop_select ? in_velocity : in_acceleration;
      tgt_r  <= in_target;
      sel_r  <= in_loop_select;
    end
    if (cmd.calc_err) begin
      e_r <= e_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (cmd.upd_integ) begin
      deriv_r   <= deriv_nxt;
      sat_int_r <= int_hit;
    end
    if (cmd.out_load) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_int_r | out_hit;
    end
  end

  // loop state, shared by both loops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (cmd.upd_integ) begin
      integ_r <= integ_nxt;
      prev_r  <= e_r;
    end
  end

  assign out_drive_output = drive_r;
  assign out_saturated    = sat_r;

endmodule

// ===== sv/dgpid_checker.sv =====
// dgpid_checker: port-level assertions for the dual-gain PID core, and the
// bind that attaches them. Depends on dual_gain_pid_controller_core.
module dgpid_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [DATA_WIDTH-1:0]  out_drive_output,
  input logic                   out_saturated
);

  // after a sample is taken, in_stall is checked high at the start and at the end of its computation
  a_busy_span: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall ##10 in_stall)
    else $error("input taken while a sample was still in work");

  // a new result is handed over only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while sequencer busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_drive_output) && $stable(out_saturated)))
    else $error("stalled result changed");

endmodule

bind dual_gain_pid_controller_core dgpid_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_dgpid_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_drive_output (out_drive_output),
  .out_saturated    (out_saturated)
);

// ===== tb/sv/pid_drive_checker.sv =====
`timescale 1ns / 100ps
// pid_drive_checker: watches the sample, drive and gain channels of the
// dual-gain PID core, predicts every drive transaction and compares it.
// Depends on dgpid_pkg.
module pid_drive_checker
  import dgpid_pkg::*;
#(
  parameter int DW   = 32,
  parameter int FRAC = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [DW-1:0] in_velocity,
  input  logic signed [DW-1:0] in_acceleration,
  input  logic signed [DW-1:0] in_target,
  input  logic                 in_loop_select,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [DW-1:0] out_drive_output,
  input  logic                 out_saturated,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam longint DATA_MAX  = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint DATA_MIN  = -DATA_MAX - 1;
  localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  // dt = 0.01 in Q format, rounded to nearest
  localparam longint STEP_Q    = ((64'sd1 <<< FRAC) + STEP_RECIP / 2) / STEP_RECIP;

  localparam gain_set_t VEL_RESET = '{kp: 32'sd3276800, ki: 32'sd983040, kd: 32'sd6554};
  localparam gain_set_t ACC_RESET = '{kp: 32'sd52429, ki: 32'sd6554, kd: 32'sd0};

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 sat;
  } drive_t;

  gain_set_t vel_gains, acc_gains;
  longint    integral_acc, last_error;
  drive_t    drive_expect_q[$];
  int        mismatches = 0;

  // one PID step; updates integral and last error as the core does
  function automatic drive_t predict_drive(input logic signed [DW-1:0] vel, acc, tgt,
                                           input logic vel_loop);
    gain_set_t            g;
    logic signed [DW-1:0] meas;
    longint               diff, err, isum, deriv;
    logic signed [127:0]  kp_w, ki_w, kd_w, e_w, i_w, d_w, wsum, shifted;
    drive_t               r;
    g     = vel_loop ? vel_gains : acc_gains;
    meas  = vel_loop ? vel : acc;
    r.sat = 1'b0;
    diff  = longint'(tgt) - longint'(meas);
    // error clamp does not raise the flag
    if (diff > DATA_MAX) err = DATA_MAX;
    else if (diff < DATA_MIN) err = DATA_MIN;
    else err = diff;
    isum = integral_acc + ((err * STEP_Q) >>> FRAC);
    if (isum > INTEG_MAX) begin
      isum  = INTEG_MAX;
      r.sat = 1'b1;
    end else if (isum < INTEG_MIN) begin
      isum  = INTEG_MIN;
      r.sat = 1'b1;
    end
    deriv        = (err - last_error) * STEP_RECIP;
    integral_acc = isum;
    last_error   = err;
    kp_w    = $signed(g.kp);
    ki_w    = $signed(g.ki);
    kd_w    = $signed(g.kd);
    e_w     = err;
    i_w     = isum;
    d_w     = deriv;
    wsum    = kp_w * e_w + ki_w * i_w + kd_w * d_w;
    shifted = wsum >>> FRAC;
    if (shifted > DATA_MAX) begin
      shifted = DATA_MAX;
      r.sat   = 1'b1;
    end else if (shifted < DATA_MIN) begin
      shifted = DATA_MIN;
      r.sat   = 1'b1;
    end
    r.drive = shifted[DW-1:0];
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      vel_gains    = VEL_RESET;
      acc_gains    = ACC_RESET;
      integral_acc = 0;
      last_error   = 0;
      drive_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VEL_KP: vel_gains.kp = cfg_data;
          REG_VEL_KI: vel_gains.ki = cfg_data;
          REG_VEL_KD: vel_gains.kd = cfg_data;
          REG_ACC_KP: acc_gains.kp = cfg_data;
          REG_ACC_KI: acc_gains.ki = cfg_data;
          REG_ACC_KD: acc_gains.kd = cfg_data;
          default: ;  // spare indexes are dropped
        endcase
      end
      if (in_valid && !in_stall)
        drive_expect_q.push_back(predict_drive(in_velocity, in_acceleration, in_target,
                                               in_loop_select));
      if (out_valid && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          flag($sformatf("drive %0d arrived with nothing pending", out_drive_output));
        end else begin
          want = drive_expect_q.pop_front();
          if (out_drive_output !== want.drive)
            flag($sformatf("drive_output: expected %0d, got %0d", want.drive,
                           out_drive_output));
          if (out_saturated !== want.sat)
            flag($sformatf("saturated: expected %0b, got %0b", want.sat, out_saturated));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= drive_expect_q.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for dual_gain_pid_controller_core.
// Depends on dgpid_pkg, the core and pid_drive_checker.
module tb_top;
  import dgpid_pkg::*;

  localparam int DW          = 32;
  localparam int FRAC        = 16;
  localparam int LIMIT       = 500_000;   // cycles
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_AT     = 500;       // result count at which the sink goes quiet
  localparam int HOLD_CYCLES = 200;
  localparam int SPAN        = 100 << FRAC;  // +/-100.0
  localparam int NOISE       = 1 << FRAC;    // +/-1.0 around the tracked value
  localparam int GAIN_SPAN   = 4 << FRAC;

  localparam logic LOOP_VEL = 1'b1;
  localparam logic LOOP_ACC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] Q_ONE = 1 << FRAC;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [DW-1:0]  in_velocity = '0;
  logic signed [DW-1:0]  in_acceleration = '0;
  logic signed [DW-1:0]  in_target = '0;
  logic                  in_loop_select = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [DW-1:0]  out_drive_output;
  logic                  out_saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [GAIN_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;

  // stretches where a side never idles
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  // tracking stimulus state
  logic signed [DW-1:0] setpoint, bias, meas;
  logic                 loop_sel;

  always #4 clk = ~clk;

  dual_gain_pid_controller_core #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_velocity     (in_velocity),
    .in_acceleration (in_acceleration),
    .in_target       (in_target),
    .in_loop_select  (in_loop_select),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_output(out_drive_output),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  pid_drive_checker #(
    .DW  (DW),
    .FRAC(FRAC)
  ) drive_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_velocity     (in_velocity),
    .in_acceleration (in_acceleration),
    .in_target       (in_target),
    .in_loop_select  (in_loop_select),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_output(out_drive_output),
    .out_saturated   (out_saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sample values: mostly moderate Q16.16 numbers, some full-range words and
  // the corner codes.
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return '1;
          default: return 1;
        endcase
      end
      1, 2:    return $urandom();
      default: return int'($urandom_range(0, 2 * SPAN)) - SPAN;
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return $urandom();
      default: return int'($urandom_range(0, 2 * GAIN_SPAN)) - GAIN_SPAN;
    endcase
  endfunction

  function automatic gain_set_t same_gains(input logic signed [GAIN_W-1:0] g);
    return '{kp: g, ki: g, kd: g};
  endfunction

  // One input transaction. A random gap (or none in a calm stretch) drops
  // valid first; the payload then holds until the core takes it.
  task automatic send_sample(input logic signed [DW-1:0] vel, acc, tgt,
                             input logic sel);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_velocity     <= vel;
    in_acceleration <= acc;
    in_target       <= tgt;
    in_loop_select  <= sel;
    do @(posedge clk); while (in_stall);
  endtask

  // Lowers valid, then waits for every predicted drive value to come back.
  // Each sample yields exactly one result, so an empty queue means the core is idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // cfg_valid stays high across a batch; only the payload moves on.
  task automatic put_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_gains(input gain_set_t vel, input gain_set_t acc);
    put_gain(REG_VEL_KP, vel.kp);
    put_gain(REG_VEL_KI, vel.ki);
    put_gain(REG_VEL_KD, vel.kd);
    put_gain(REG_ACC_KP, acc.kp);
    put_gain(REG_ACC_KI, acc.ki);
    put_gain(REG_ACC_KD, acc.kd);
    // a write to a spare index must leave every gain alone
    put_gain($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: random stall per transaction, calm stretches, and one long
  // hold-off so the result register and hand-off fill and in_stall rises.
  initial begin : result_sink
    int n;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) n = HOLD_CYCLES;
      else n = recv_calm ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : stimulus
    gain_set_t vel_set, acc_set;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples on the reset gains.
    send_sample('0, '0, '0, LOOP_VEL);
    send_sample('0, 32'sh1234, Q_ONE, LOOP_VEL);
    send_sample(Q_MAX, Q_ONE >>> 2, Q_ONE >>> 1, LOOP_ACC);
    // error clamped at the top, then at the bottom: derivative jumps full scale
    send_sample(Q_MIN, '0, Q_MAX, LOOP_VEL);
    send_sample(Q_MAX, '0, Q_MIN, LOOP_VEL);
    send_sample(Q_MAX, Q_MIN, Q_MAX, LOOP_ACC);
    send_sample(Q_MIN, Q_MAX, Q_MIN, LOOP_ACC);
    // zero error with the unused measurement at its extremes
    send_sample(Q_MAX, Q_MIN, Q_MAX, LOOP_VEL);
    send_sample(Q_MAX, Q_MIN, Q_MIN, LOOP_ACC);
    // alternating bit patterns and one-LSB steps
    send_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, LOOP_VEL);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, LOOP_ACC);
    send_sample('0, '0, 1, LOOP_VEL);
    send_sample('0, '0, '1, LOOP_ACC);
    send_sample('1, 1, '0, LOOP_VEL);
    // drive well past full scale on the velocity gains
    send_sample(-(200 * Q_ONE), '0, 200 * Q_ONE, LOOP_VEL);
    send_sample(200 * Q_ONE, '0, -(200 * Q_ONE), LOOP_VEL);
    send_sample('0, Q_ONE, '0, LOOP_ACC);
    send_sample('0, -Q_ONE, '0, LOOP_ACC);
    send_sample(Q_MIN, Q_MIN, Q_MIN, LOOP_VEL);
    send_sample(Q_MAX, Q_MAX, Q_MAX, LOOP_ACC);
    wait_idle();

    // Random phases, each on a fresh gain setting. Phases 1 to 3 pin every
    // gain at its maximum, minimum and zero; the others draw them at random.
    setpoint = pick_value();
    bias     = '0;
    loop_sel = LOOP_VEL;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          vel_set = same_gains(Q_MAX);
          acc_set = same_gains(Q_MAX);
        end
        2: begin
          vel_set = same_gains(Q_MIN);
          acc_set = same_gains(Q_MIN);
        end
        3: begin
          vel_set = same_gains('0);
          acc_set = same_gains('0);
        end
        default: begin
          vel_set = '{kp: pick_gain(), ki: pick_gain(), kd: pick_gain()};
          acc_set = '{kp: pick_gain(), ki: pick_gain(), kd: pick_gain()};
        end
      endcase
      program_gains(vel_set, acc_set);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 7) begin
          // Tracking: the measurement sits near the setpoint with a held
          // offset, so the integral keeps drifting one way between jumps.
          if ($urandom_range(0, 24) == 0) begin
            setpoint = pick_value();
            bias     = int'($urandom_range(0, 2 * SPAN)) - SPAN;
          end
          if ($urandom_range(0, 31) == 0) loop_sel = ~loop_sel;
          meas = setpoint - bias + (int'($urandom_range(0, 2 * NOISE)) - NOISE);
          if (loop_sel == LOOP_VEL) send_sample(meas, pick_value(), setpoint, loop_sel);
          else send_sample(pick_value(), meas, setpoint, loop_sel);
        end else begin
          send_sample(pick_value(), pick_value(), pick_value(),
                      1'($urandom_range(0, 1)));
        end
      end
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== dual_gain_pid_controller_core.f =====
sv/dgpid_pkg.sv
sv/dgpid_regs.sv
sv/dgpid_ctrl.sv
sv/dgpid_dp.sv
sv/dual_gain_pid_controller_core.sv
sv/dgpid_checker.sv
tb/sv/pid_drive_checker.sv
tb/sv/tb_top.sv
